// File: rtl/stepper_speed_to_timer_top_macros.svh
// assertion macros for the stepper speed to timer block
`ifndef STEPPER_SPEED_TO_TIMER_TOP_MACROS_SVH
`define STEPPER_SPEED_TO_TIMER_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define SSTT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sstt assertion failed");

// next-cycle implication, disabled during reset
`define SSTT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sstt assertion failed");

`endif

// File: rtl/sstt_pkg.sv
// types, constants and codes shared by the stepper speed to timer block
`timescale 1ns / 1ps
`default_nettype none

package sstt_pkg;

    localparam int MAX_COUNT       = 255;
    localparam int SPEED_FRAC_BITS = 8;

    localparam int SPEED_W = 24;
    localparam int THR_W   = 23;
    localparam int SPR_W   = 16;
    localparam int CLK_W   = 30;
    localparam int TOP_W   = 8;
    localparam int CFG_IDX_W = 3;

    localparam int MAG_W       = SPEED_W;
    localparam int PROD_W      = MAG_W + SPR_W;
    localparam int PSHIFT_MAX  = 10;
    localparam int DEN_W       = PROD_W + PSHIFT_MAX;
    localparam int NUM_MULT    = 30;
    localparam int NUM_W       = CLK_W + 5 + SPEED_FRAC_BITS;
    localparam int REM_W       = ((NUM_W + 1 > DEN_W) ? NUM_W + 1 : DEN_W) + 1;
    localparam int QBITS       = $clog2(MAX_COUNT + 2);
    localparam int DS_W        = REM_W + QBITS;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [THR_W-1:0] THR1024_RESET = THR_W'(15360);
    localparam logic [THR_W-1:0] THR256_RESET  = THR_W'(61440);
    localparam logic [THR_W-1:0] THR64_RESET   = THR_W'(245760);
    localparam logic [SPR_W-1:0] SPR_RESET     = SPR_W'(3200);
    localparam logic [CLK_W-1:0] CLK_RESET     = CLK_W'(16000000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THR1024 = 3'd0,
        CFG_THR256  = 3'd1,
        CFG_THR64   = 3'd2,
        CFG_SPR     = 3'd3,
        CFG_CLK     = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PSEL_DIV8    = 2'd0,
        PSEL_DIV64   = 2'd1,
        PSEL_DIV256  = 2'd2,
        PSEL_DIV1024 = 2'd3
    } t_psel;

    typedef struct packed {
        logic signed [SPEED_W-1:0] speed_rpm;
        logic                      motor_index;
    } t_in_req;

    typedef struct packed {
        logic             direction;
        t_psel            prescaler_select;
        logic [TOP_W-1:0] compare_top;
        logic             clamped_high;
        logic             clamped_low;
    } t_out_rsp;

    typedef struct packed {
        logic              dir;
        t_psel             sel;
        logic [PROD_W-1:0] prod;
    } t_cmd;

    // numerator of the period: clock * 30 scaled by the speed fraction
    function automatic logic [NUM_W-1:0] calc_num(input logic [CLK_W-1:0] clk_hz);
        logic [NUM_W-1:0] prod;
        prod = NUM_W'(clk_hz) * NUM_W'(NUM_MULT);
        return prod << SPEED_FRAC_BITS;
    endfunction

endpackage

`default_nettype wire

// File: rtl/sstt_front.sv
// front end: config registers, request intake, direction and prescaler pick, product
`timescale 1ns / 1ps
`default_nettype none

module sstt_front
    import sstt_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CLK_W-1:0]     i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_in_req              i_in_req,
    output logic                      o_cmd_valid,
    input  wire logic                 i_cmd_ready,
    output t_cmd                      o_cmd,
    output logic [NUM_W-1:0]          o_num
);

    logic [THR_W-1:0] r_thr1024;
    logic [THR_W-1:0] r_thr256;
    logic [THR_W-1:0] r_thr64;
    logic [SPR_W-1:0] r_spr;
    logic [NUM_W-1:0] r_num;
    logic             r_v;
    t_cmd             r_cmd;
    t_cmd             n_cmd;
    logic             neg;
    logic [MAG_W-1:0] mag;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_v || i_cmd_ready;
    assign o_cmd_valid = r_v;
    assign o_cmd       = r_cmd;
    assign o_num       = r_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr1024 <= THR1024_RESET;
            r_thr256  <= THR256_RESET;
            r_thr64   <= THR64_RESET;
            r_spr     <= SPR_RESET;
            r_num     <= calc_num(CLK_RESET);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_THR1024: r_thr1024 <= i_cfg_data[THR_W-1:0];
                CFG_THR256:  r_thr256  <= i_cfg_data[THR_W-1:0];
                CFG_THR64:   r_thr64   <= i_cfg_data[THR_W-1:0];
                CFG_SPR:     r_spr     <= i_cfg_data[SPR_W-1:0];
                CFG_CLK:     r_num     <= calc_num(i_cfg_data);
                default: ;
            endcase
        end
    end

    always_comb begin
        neg = i_in_req.speed_rpm[SPEED_W-1];
        // two's complement of the most negative value wraps to 2^23, as wanted
        mag = neg ? MAG_W'(~i_in_req.speed_rpm) + MAG_W'(1) : MAG_W'(i_in_req.speed_rpm);
        n_cmd.dir = !neg ^ i_in_req.motor_index;
        if (mag <= MAG_W'(r_thr1024)) begin
            n_cmd.sel = PSEL_DIV1024;
        end else if (mag <= MAG_W'(r_thr256)) begin
            n_cmd.sel = PSEL_DIV256;
        end else if (mag <= MAG_W'(r_thr64)) begin
            n_cmd.sel = PSEL_DIV64;
        end else begin
            n_cmd.sel = PSEL_DIV8;
        end
        n_cmd.prod = PROD_W'(mag) * PROD_W'(r_spr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_in_ready) begin
            r_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

`default_nettype wire

// File: rtl/sstt_fifo.sv
// short queue of classified requests between front and back
`timescale 1ns / 1ps
`default_nettype none

module sstt_fifo
    import sstt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_wr_valid,
    output logic      o_wr_ready,
    input  wire t_cmd i_wr_data,
    output logic      o_rd_valid,
    input  wire logic i_rd_ready,
    output t_cmd      o_rd_data
);

    t_cmd               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_AW:0]   r_count;
    logic               wr_en;
    logic               rd_en;

    assign o_wr_ready = r_count != (FIFO_AW + 1)'(FIFO_DEPTH);
    assign o_rd_valid = r_count != '0;
    assign o_rd_data  = r_mem[r_rd_ptr];
    assign wr_en      = i_wr_valid && o_wr_ready;
    assign rd_en      = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + (FIFO_AW + 1)'(1);
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - (FIFO_AW + 1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/sstt_back.sv
// back end: pipelined rounding divider, saturation and result register
`timescale 1ns / 1ps
`default_nettype none

module sstt_back
    import sstt_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic             i_cmd_valid,
    output logic                  o_cmd_ready,
    input  wire t_cmd             i_cmd,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output t_out_rsp              o_out_rsp
);

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [REM_W-1:0] d;
        logic [QBITS-1:0] q;
        logic             sat;
        logic             dir;
        t_psel            sel;
    } t_div;

    function automatic t_div div_step(input t_div s, input int unsigned k);
        logic [DS_W-1:0] dsh;
        logic            ge;
        t_div            r;
        dsh = DS_W'(s.d) << k;
        ge  = DS_W'(s.rem) >= dsh;
        r   = s;
        if (ge) begin
            r.rem = s.rem - dsh[REM_W-1:0];
        end
        r.q = {s.q[QBITS-2:0], ge};
        return r;
    endfunction

    t_div             r_st [QBITS];
    logic             r_v  [QBITS];
    logic             r_out_v;
    t_out_rsp         r_rsp;
    logic             adv  [QBITS+1];
    t_div             n_st0;
    t_div             last;
    t_out_rsp         n_rsp;
    logic [DEN_W-1:0] den;
    logic [3:0]       shamt;

    always_comb begin
        adv[QBITS] = !r_out_v || i_out_ready;
        for (int s = QBITS - 1; s >= 0; s--) begin
            adv[s] = !r_v[s] || adv[s+1];
        end
    end

    assign o_cmd_ready = adv[0];
    assign o_out_valid = r_out_v;
    assign o_out_rsp   = r_rsp;

    // denominator and rounded numerator: q = (2*num + den) / (2*den)
    always_comb begin
        unique case (i_cmd.sel)
            PSEL_DIV8:    shamt = 4'd3;
            PSEL_DIV64:   shamt = 4'd6;
            PSEL_DIV256:  shamt = 4'd8;
            PSEL_DIV1024: shamt = 4'd10;
            default:      shamt = 4'd3;
        endcase
        den       = DEN_W'(i_cmd.prod) << shamt;
        n_st0.rem = REM_W'({i_num, 1'b0}) + REM_W'(den);
        n_st0.d   = REM_W'({den, 1'b0});
        n_st0.q   = '0;
        // zero denominator also lands here
        n_st0.sat = DS_W'(n_st0.rem) >= (DS_W'(n_st0.d) << QBITS);
        n_st0.dir = i_cmd.dir;
        n_st0.sel = i_cmd.sel;
    end

    always_comb begin
        last                   = div_step(r_st[QBITS-1], 0);
        n_rsp.direction        = last.dir;
        n_rsp.prescaler_select = last.sel;
        n_rsp.clamped_high     = last.sat || (last.q > QBITS'(MAX_COUNT + 1));
        n_rsp.clamped_low      = !n_rsp.clamped_high && (last.q == '0);
        if (n_rsp.clamped_high) begin
            n_rsp.compare_top = TOP_W'(MAX_COUNT);
        end else if (n_rsp.clamped_low) begin
            n_rsp.compare_top = '0;
        end else begin
            n_rsp.compare_top = TOP_W'(last.q - QBITS'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < QBITS; s++) begin
                r_v[s] <= 1'b0;
            end
            r_out_v <= 1'b0;
        end else begin
            if (adv[0]) begin
                r_v[0] <= i_cmd_valid;
            end
            for (int s = 1; s < QBITS; s++) begin
                if (adv[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
            if (adv[QBITS]) begin
                r_out_v <= r_v[QBITS-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_st[0] <= n_st0;
        end
        for (int s = 1; s < QBITS; s++) begin
            if (adv[s]) begin
                r_st[s] <= div_step(r_st[s-1], QBITS - s);
            end
        end
        if (adv[QBITS]) begin
            r_rsp <= n_rsp;
        end
    end

endmodule

`default_nettype wire

// File: rtl/stepper_speed_to_timer_top.sv
// throughput: one request per cycle while the output is not stalled, set by the nine-stage divider pipeline
// front register, 4-entry queue, divider stage per quotient bit, result register
// reset: synchronous active low, clears valids and loads default config values
// config writes take effect at once and are always accepted
`timescale 1ns / 1ps
`default_nettype none
`include "stepper_speed_to_timer_top_macros.svh"

module stepper_speed_to_timer_top
    import sstt_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CLK_W-1:0]     i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_in_req              i_in_req,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_out_rsp                  o_out_rsp
);

    logic             fr_valid;
    logic             fr_ready;
    t_cmd             fr_cmd;
    logic             bk_valid;
    logic             bk_ready;
    t_cmd             bk_cmd;
    logic [NUM_W-1:0] num;
    logic             rsp_hi;
    logic             rsp_lo;
    logic [TOP_W-1:0] rsp_top;

    assign rsp_hi  = o_out_rsp.clamped_high;
    assign rsp_lo  = o_out_rsp.clamped_low;
    assign rsp_top = o_out_rsp.compare_top;

    sstt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_cmd_valid (fr_valid),
        .i_cmd_ready (fr_ready),
        .o_cmd       (fr_cmd),
        .o_num       (num)
    );

    sstt_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (fr_valid),
        .o_wr_ready (fr_ready),
        .i_wr_data  (fr_cmd),
        .o_rd_valid (bk_valid),
        .i_rd_ready (bk_ready),
        .o_rd_data  (bk_cmd)
    );

    sstt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_num       (num),
        .i_cmd_valid (bk_valid),
        .o_cmd_ready (bk_ready),
        .i_cmd       (bk_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_rsp   (o_out_rsp)
    );

    `SSTT_ASSERT_IMPL(a_flags_exclusive, o_out_valid, !(rsp_hi && rsp_lo))
    `SSTT_ASSERT_IMPL(a_high_is_max, o_out_valid && rsp_hi, rsp_top == TOP_W'(MAX_COUNT))
    `SSTT_ASSERT_IMPL(a_low_is_zero, o_out_valid && rsp_lo, rsp_top == '0)
    `SSTT_ASSERT_NEXT(a_queue_drains, bk_valid && bk_ready && !fr_valid, fr_ready)

endmodule

`default_nettype wire

// File: tb/sstt_timer_checker.sv
// checker that predicts each timer setting of the speed to timer block and compares it
`timescale 1ns / 1ps
`default_nettype none

module sstt_timer_checker
    import sstt_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    input  wire logic                 i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CLK_W-1:0]     i_cfg_data,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_ready,
    input  wire t_in_req              i_in_req,
    input  wire logic                 i_out_valid,
    input  wire logic                 i_out_ready,
    input  wire t_out_rsp             i_out_rsp,
    output int                        o_errors,
    output int                        o_pending,
    output int                        o_checked
);

    logic [THR_W-1:0] thr1024 = THR1024_RESET;
    logic [THR_W-1:0] thr256  = THR256_RESET;
    logic [THR_W-1:0] thr64   = THR64_RESET;
    logic [SPR_W-1:0] steps   = SPR_RESET;
    logic [CLK_W-1:0] clock   = CLK_RESET;

    t_out_rsp timer_settings[$];

    initial begin
        o_errors  = 0;
        o_checked = 0;
        o_pending = 0;
    end

    function automatic t_out_rsp timer_setting(input t_in_req req);
        t_out_rsp           res;
        logic [SPEED_W-1:0] mag;
        logic               negative;
        int unsigned        shift;
        logic [63:0]        num;
        logic [63:0]        den;
        logic [63:0]        quo;
        res      = '0;
        negative = req.speed_rpm[SPEED_W-1];
        mag      = negative ? -req.speed_rpm : req.speed_rpm;
        res.direction = ~negative ^ req.motor_index;
        if (mag <= thr1024) begin
            res.prescaler_select = PSEL_DIV1024;
            shift = 10;
        end else if (mag <= thr256) begin
            res.prescaler_select = PSEL_DIV256;
            shift = 8;
        end else if (mag <= thr64) begin
            res.prescaler_select = PSEL_DIV64;
            shift = 6;
        end else begin
            res.prescaler_select = PSEL_DIV8;
            shift = 3;
        end
        if (mag == 0 || steps == 0) begin
            res.compare_top  = TOP_W'(MAX_COUNT);
            res.clamped_high = 1'b1;
        end else begin
            // half period in timer ticks, rounded half up
            num = (64'(clock) * NUM_MULT) << SPEED_FRAC_BITS;
            den = (64'(mag) * 64'(steps)) << shift;
            quo = (2 * num + den) / (2 * den);
            if (quo == 0) begin
                res.clamped_low = 1'b1;
            end else if (quo - 1 > MAX_COUNT) begin
                res.compare_top  = TOP_W'(MAX_COUNT);
                res.clamped_high = 1'b1;
            end else begin
                res.compare_top = TOP_W'(quo - 1);
            end
        end
        return res;
    endfunction

    task automatic check_field(input string name, input logic [TOP_W-1:0] want_v,
                               input logic [TOP_W-1:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_rsp want;
        if (!i_rst_n) begin
            thr1024 = THR1024_RESET;
            thr256  = THR256_RESET;
            thr64   = THR64_RESET;
            steps   = SPR_RESET;
            clock   = CLK_RESET;
            timer_settings.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (timer_settings.size() == 0) begin
                    $error("timer setting with no request waiting: %p", i_out_rsp);
                    o_errors++;
                end else begin
                    want = timer_settings.pop_front();
                    check_field("direction", want.direction, i_out_rsp.direction);
                    check_field("prescaler_select", want.prescaler_select,
                                i_out_rsp.prescaler_select);
                    check_field("compare_top", want.compare_top, i_out_rsp.compare_top);
                    check_field("clamped_high", want.clamped_high, i_out_rsp.clamped_high);
                    check_field("clamped_low", want.clamped_low, i_out_rsp.clamped_low);
                    o_checked++;
                end
            end
            if (i_in_valid && i_in_ready) begin
                timer_settings.push_back(timer_setting(i_in_req));
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_THR1024: thr1024 = i_cfg_data[THR_W-1:0];
                    CFG_THR256:  thr256  = i_cfg_data[THR_W-1:0];
                    CFG_THR64:   thr64   = i_cfg_data[THR_W-1:0];
                    CFG_SPR:     steps   = i_cfg_data[SPR_W-1:0];
                    CFG_CLK:     clock   = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending <= timer_settings.size();
    end

endmodule

`default_nettype wire

// File: tb/tb.sv
// top of the speed to timer testbench: clock, reset, request and register stimulus, verdict
`timescale 1ns / 1ps
`default_nettype none

module tb;
    import sstt_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 47;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = CFG_IDX_W'(CFG_CLK) + 1'b1;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CLK_W-1:0]     cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    t_in_req              in_req    = '0;
    logic                 out_ready = 1'b0;
    logic                 stall_on  = 1'b1;
    logic                 cfg_ready;
    logic                 in_ready;
    logic                 out_valid;
    t_out_rsp             out_rsp;

    int errors;
    int pending;
    int checked;
    int cycles   = 0;
    int sent     = 0;
    int settings = 0;

    logic [THR_W-1:0] cur_thr [3];

    stepper_speed_to_timer_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_rsp   (out_rsp)
    );

    sstt_timer_checker i_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_req    (in_req),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_rsp   (out_rsp),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    always @(posedge clk) begin
        out_ready <= !stall_on || ($urandom_range(99) >= 29);
    end

    // random value of up to w bits, small values as likely as large ones
    function automatic logic [31:0] spread(input int w);
        return $urandom >> (32 - $urandom_range(1, w));
    endfunction

    task automatic push_speed(input logic [SPEED_W-1:0] speed, input logic motor);
        while (stall_on && $urandom_range(99) < 29) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= '{speed_rpm: speed, motor_index: motor};
        do @(posedge clk); while (!in_ready);
        sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // leaves cfg_valid high; the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CLK_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic load_config(input logic [THR_W-1:0] t1024, input logic [THR_W-1:0] t256,
                               input logic [THR_W-1:0] t64, input logic [SPR_W-1:0] spr,
                               input logic [CLK_W-1:0] hz);
        write_reg(CFG_THR1024, CLK_W'(t1024));
        write_reg(CFG_THR256, CLK_W'(t256));
        write_reg(CFG_THR64, CLK_W'(t64));
        write_reg(CFG_SPR, CLK_W'(spr));
        write_reg(CFG_CLK, hz);
        cfg_valid <= 1'b0;
        cur_thr   = '{t1024, t256, t64};
        settings++;
    endtask

    task automatic random_config();
        logic [THR_W-1:0] t [3];
        logic [SPR_W-1:0] spr;
        logic [CLK_W-1:0] hz;
        if ($urandom_range(3) == 0) begin
            foreach (t[i]) t[i] = THR_W'($urandom);
        end else begin
            t[2] = THR_W'(spread(THR_W));
            t[1] = t[2] >> $urandom_range(4);
            t[0] = t[1] >> $urandom_range(4);
        end
        case ($urandom_range(5))
            0:       spr = SPR_W'($urandom);
            1:       spr = $urandom_range(1) ? SPR_W'(1) : '1;
            default: spr = SPR_W'(200 * $urandom_range(1, 64));
        endcase
        case ($urandom_range(5))
            0:       hz = CLK_W'($urandom);
            1:       hz = CLK_W'(spread(CLK_W));
            default: hz = CLK_W'($urandom_range(1000000, 100000000));
        endcase
        load_config(t[0], t[1], t[2], spr, hz);
    endtask

    task automatic push_random_speed();
        logic [SPEED_W-1:0] mag;
        case ($urandom_range(9))
            0, 1:    mag = SPEED_W'($urandom);
            2:       mag = SPEED_W'(cur_thr[$urandom_range(2)]) + SPEED_W'($urandom_range(1));
            default: mag = SPEED_W'(spread(SPEED_W - 1));
        endcase
        push_speed($urandom_range(1) ? -mag : mag, 1'($urandom_range(1)));
    endtask

    initial begin
        cur_thr = '{THR1024_RESET, THR256_RESET, THR64_RESET};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default settings: zero, extremes, threshold edges
        push_speed(24'h000000, 1'b0);
        push_speed(24'h000000, 1'b1);
        push_speed(24'h7fffff, 1'b0);
        push_speed(24'h800000, 1'b1);
        push_speed(24'h000001, 1'b0);
        push_speed(24'hffffff, 1'b1);
        push_speed(SPEED_W'(15360), 1'b0);
        push_speed(SPEED_W'(15361), 1'b1);
        push_speed(-SPEED_W'(61440), 1'b0);
        push_speed(SPEED_W'(61441), 1'b0);
        push_speed(SPEED_W'(245760), 1'b1);
        push_speed(-SPEED_W'(245761), 1'b0);
        wait_drained();

        // zero thresholds, slowest clock, most steps: low clamp for nonzero speeds, high clamp for zero
        load_config('0, '0, '0, '1, CLK_W'(1));
        push_speed(24'h800000, 1'b0);
        push_speed(24'h000001, 1'b1);
        push_speed(24'h000000, 1'b0);
        wait_drained();

        // zero steps per revolution, top thresholds, a 1 GHz clock
        load_config('1, '1, '1, '0, CLK_W'(1000000000));
        push_speed(24'h123456, 1'b0);
        push_speed(-SPEED_W'(24'h7fffff), 1'b1);
        wait_drained();

        // unordered thresholds and a stopped clock
        load_config(THR_W'(100), THR_W'(50), THR_W'(10), SPR_W'(3200), '0);
        push_speed(SPEED_W'(5), 1'b1);
        push_speed(SPEED_W'(75), 1'b0);
        push_speed(-SPEED_W'(150), 1'b0);
        wait_drained();

        // writes to unused indexes must leave the settings alone
        load_config(THR1024_RESET, THR256_RESET, THR64_RESET, SPR_RESET, CLK_RESET);
        for (int idx = CFG_IDX_SPARE; idx < (1 << CFG_IDX_W); idx++) begin
            write_reg(CFG_IDX_W'(idx), CLK_W'($urandom));
        end
        cfg_valid <= 1'b0;
        push_speed(SPEED_W'(25600), 1'b0);
        push_speed(-SPEED_W'(76800), 1'b1);

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            stall_on <= (phase != 2);
            if (phase == PHASES - 2) begin
                load_config('0, '0, '0, SPR_W'(1), CLK_W'(1));
            end else if (phase == PHASES - 1) begin
                load_config('1, '1, '1, '1, '1);
            end else begin
                random_config();
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                push_random_speed();
                if (n == PHASE_ITEMS / 2 && phase % 3 == 0) begin
                    wait_drained();
                end
            end
        end

        wait_drained();
        repeat (20) @(posedge clk);
        $display("sent %0d speed requests over %0d register settings, %0d results checked",
                 sent, settings, checked);
        $display("covered zero and extreme speeds, threshold edges, both motors, clamps, "
                 , "unused register indexes and random stalls");
        if (errors == 0 && pending == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+rtl
rtl/sstt_pkg.sv
rtl/sstt_front.sv
rtl/sstt_fifo.sv
rtl/sstt_back.sv
rtl/stepper_speed_to_timer_top.sv
tb/sstt_timer_checker.sv
tb/tb.sv
